// File: rtl/core/s2c_pkg.sv
// shared constants and types of the sphere to cube mapper
package s2c_pkg;

    // field format
    localparam int FIELD_W       = 18;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [63:0] FIELD_MAX = 64'd131071;

    // internal unsigned work format
    localparam int WORK_FRAC = 28;
    localparam int W_MAG     = WORK_FRAC + 1;          // saturated magnitude
    localparam int W_A       = WORK_FRAC + 2;          // floor(2*a*a)
    localparam int W_T12     = W_A + 4;                // 12*A before scaling
    localparam int W_MI      = WORK_FRAC + 3;          // |B - A - 3|
    localparam int W_RAD     = 2 * W_MI;               // radicand of the inner root
    localparam int W_RAD2    = W_MI + WORK_FRAC - 1;   // radicand of the outer roots
    localparam int W_ROOT2   = W_RAD2 / 2;
    localparam int PAY_W_DEF = 8;

    // map_mode register codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_STD = 2'd0;
    localparam t_mode MODE_ALT = 2'd1;
    localparam t_mode MODE_YUP = 2'd2;

    // how the cubify results go back to x, y, z
    typedef enum logic [1:0] {
        PERM_ID      = 2'd0,   // x=t0 y=t1 z=t2
        PERM_SWAP_YZ = 2'd1,   // x=t0 y=t2 z=t1
        PERM_X_STD   = 2'd2,   // x=t1 y=t0 z=t2
        PERM_X_ALT   = 2'd3    // x=t2 y=t0 z=t1
    } t_perm;

    // sign of a component, zero counts as its own sign
    typedef struct packed {
        logic nz;
        logic neg;
    } t_sgn;

    // side information that travels with an item
    typedef struct packed {
        t_perm perm;
        t_sgn  sp;
        t_sgn  sq;
        t_sgn  sr;
    } t_side;

endpackage

// File: rtl/core/s2c_if.sv
// channel interfaces of the sphere to cube mapper

// sphere point channel
interface s2c_in_if;
    import s2c_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] sphere_x;
    logic signed [FIELD_W-1:0] sphere_y;
    logic signed [FIELD_W-1:0] sphere_z;
    modport source (output valid, output sphere_x, output sphere_y, output sphere_z,
                    input ready);
    modport sink (input valid, input sphere_x, input sphere_y, input sphere_z,
                  output ready);
endinterface

// cube point channel
interface s2c_out_if;
    import s2c_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] cube_x;
    logic signed [FIELD_W-1:0] cube_y;
    logic signed [FIELD_W-1:0] cube_z;
    modport source (output valid, output cube_x, output cube_y, output cube_z,
                    input ready);
    modport sink (input valid, input cube_x, input cube_y, input cube_z,
                  output ready);
endinterface

// map_mode register write channel
interface s2c_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] map_mode;
    modport source (output valid, output map_mode, input ready);
    modport sink (input valid, input map_mode, output ready);
endinterface

// File: rtl/core/s2c_sqrt.sv
// pipelined integer square root, one result bit per stage
module s2c_sqrt #(
    parameter int RAD_W = s2c_pkg::W_RAD,
    parameter int PAY_W = s2c_pkg::PAY_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic [PAY_W-1:0]   i_pay,
    output logic               o_vld,
    output logic [RAD_W/2-1:0] o_root,
    output logic [PAY_W-1:0]   o_pay
);
    import s2c_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    // stage inputs: index 0 is the port side, index s+1 is stage s
    logic [REM_W-1:0]  c_rem  [STAGES+1];
    logic [ROOT_W-1:0] c_root [STAGES+1];
    logic [RAD_W-1:0]  c_rad  [STAGES+1];
    logic [PAY_W-1:0]  c_pay  [STAGES+1];
    logic              c_vld  [STAGES+1];

    logic [REM_W-1:0]  r_rem  [STAGES];
    logic [ROOT_W-1:0] r_root [STAGES];
    logic [RAD_W-1:0]  r_rad  [STAGES];
    logic [PAY_W-1:0]  r_pay  [STAGES];
    logic              r_vld  [STAGES];

    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_rad[0]  = i_rad;
    assign c_pay[0]  = i_pay;
    assign c_vld[0]  = i_vld;

    // restoring root step: bring down two radicand bits, try root*4+1
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0] w_trial;
        logic [REM_W-1:0] w_test;
        logic             w_ge;

        assign c_rem[s+1]  = r_rem[s];
        assign c_root[s+1] = r_root[s];
        assign c_rad[s+1]  = r_rad[s];
        assign c_pay[s+1]  = r_pay[s];
        assign c_vld[s+1]  = r_vld[s];

        assign w_trial = {c_rem[s][REM_W-3:0], c_rad[s][RAD_W-1 -: 2]};
        assign w_test  = {1'b0, c_root[s], 2'b01};
        assign w_ge    = (w_trial >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= c_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_trial - w_test) : w_trial;
                r_root[s] <= {c_root[s][ROOT_W-2:0], w_ge};
                r_rad[s]  <= c_rad[s] << 2;
                r_pay[s]  <= c_pay[s];
            end
        end
    end

    assign o_vld  = c_vld[STAGES];
    assign o_root = c_root[STAGES];
    assign o_pay  = c_pay[STAGES];

    // the remainder of a floor root never exceeds twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (r_rem[STAGES-1] <= REM_W'({o_root, 1'b0})))
        else $error("sqrt remainder out of bound");

    // a stalled pipeline keeps its last valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_vld))
        else $error("sqrt valid moved while stalled");

endmodule

// File: rtl/core/sphere_to_cube_map.sv
// top level of the sphere to cube mapper
//
// Maps a unit-sphere point to the matching unit-cube point. Points arrive on
// i_in (valid/ready, signed fixed point with FRAC_BITS fraction bits) and the
// cube points leave on o_out in the same order, one result per point.
// The i_cfg channel writes map_mode (standard order, alternate order, or y-up
// without face selection); it is always ready and should only be written
// while no point is in flight.
// From accepted point to valid result a point passes five stages of select,
// square and radicand math, a 31 stage square root, one stage for the two
// outer radicands, two parallel 29 stage square roots and the output
// register. Throughput is one point per cycle while the receiver takes
// results: every stage is registered and the roots resolve one bit per stage.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver holds off ready the pipeline freezes in place and i_in
// ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets map_mode to the standard order.
module sphere_to_cube_map #(
    parameter int FRAC_BITS = s2c_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s2c_cfg_if.sink    i_cfg,
    s2c_in_if.sink     i_in,
    s2c_out_if.source  o_out
);
    import s2c_pkg::*;

    localparam int SH_UP = (FRAC_BITS <= WORK_FRAC) ? WORK_FRAC - FRAC_BITS : 0;
    localparam int SH_DN = (FRAC_BITS > WORK_FRAC) ? FRAC_BITS - WORK_FRAC : 0;
    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ONE_W = 64'd1 << WORK_FRAC;
    localparam logic [63:0] HALF  = (64'd1 << SH_UP) >> 1;
    localparam logic [63:0] UNIT  = (ONE_F > FIELD_MAX) ? FIELD_MAX : ONE_F;
    localparam logic [FIELD_W-1:0] UNIT_F = FIELD_W'(UNIT);
    localparam logic [W_MI-1:0] THREE_W = W_MI'(3) << WORK_FRAC;
    localparam logic [W_MI-1:0] SIX_W   = W_MI'(6) << WORK_FRAC;
    localparam int PAY1_W = 2 * W_MI + $bits(t_side);
    localparam int PAY2_W = $bits(t_perm) + 2 * $bits(t_sgn);

    // magnitude of a signed field
    function automatic logic [FIELD_W-1:0] f_mag(input logic signed [FIELD_W-1:0] v);
        return v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
    endfunction

    // saturate to one and move to the work format
    function automatic logic [W_MAG-1:0] f_work(input logic [FIELD_W-1:0] m);
        logic [63:0] w;
        w = 64'(m);
        if (w > ONE_F) w = ONE_F;
        w = (w << SH_UP) >> SH_DN;
        return w[W_MAG-1:0];
    endfunction

    // round back to the field format, saturate, apply sign
    function automatic logic [FIELD_W-1:0] f_out(input logic [W_ROOT2-1:0] r,
                                                 input t_sgn sg);
        logic [63:0] m;
        m = ((64'(r) + HALF) >> SH_UP) << SH_DN;
        if (m > UNIT) m = UNIT;
        if (!sg.nz) return '0;
        return sg.neg ? FIELD_W'(-m) : FIELD_W'(m);
    endfunction

    // face axis becomes plus or minus one
    function automatic logic [FIELD_W-1:0] f_unit(input t_sgn sg);
        if (!sg.nz) return '0;
        return sg.neg ? FIELD_W'(-UNIT_F) : UNIT_F;
    endfunction

    function automatic t_sgn f_sgn(input logic signed [FIELD_W-1:0] v);
        t_sgn s;
        s.nz  = |v;
        s.neg = v[FIELD_W-1];
        return s;
    endfunction

    logic w_en;

    // mode register
    t_mode r_mode;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STD;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.map_mode;
        end
    end

    // global advance: output register empty or being taken
    logic r_out_vld;
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // stage a: dominant axis, operand order, work-format magnitudes
    logic [FIELD_W-1:0]        w_fx, w_fy, w_fz;
    logic                      w_y_win, w_x_win;
    logic signed [FIELD_W-1:0] w_p, w_q, w_r;
    t_perm                     w_perm;
    t_side                     w_side;

    assign w_fx    = f_mag(i_in.sphere_x);
    assign w_fy    = f_mag(i_in.sphere_y);
    assign w_fz    = f_mag(i_in.sphere_z);
    assign w_y_win = (w_fy >= w_fx) && (w_fy >= w_fz);
    assign w_x_win = (w_fx >= w_fz);

    always_comb begin
        w_p    = i_in.sphere_x;
        w_q    = i_in.sphere_y;
        w_r    = i_in.sphere_z;
        w_perm = PERM_ID;
        if (r_mode == MODE_YUP) begin
            w_perm = PERM_ID;
        end else if (w_y_win) begin
            w_perm = (r_mode == MODE_ALT) ? PERM_SWAP_YZ : PERM_ID;
        end else if (w_x_win) begin
            w_p    = i_in.sphere_y;
            w_q    = i_in.sphere_x;
            w_perm = (r_mode == MODE_ALT) ? PERM_X_ALT : PERM_X_STD;
        end else begin
            w_q    = i_in.sphere_z;
            w_r    = i_in.sphere_y;
            w_perm = (r_mode == MODE_ALT) ? PERM_ID : PERM_SWAP_YZ;
        end
    end

    assign w_side.perm = w_perm;
    assign w_side.sp   = f_sgn(w_p);
    assign w_side.sq   = f_sgn(w_q);
    assign w_side.sr   = f_sgn(w_r);

    logic             r_a_vld;
    logic [W_MAG-1:0] r_a_mp, r_a_mr;
    t_side            r_a_side;

    // stage b: A and B from squares
    logic [2*W_MAG-1:0] w_pa, w_pb;
    logic               r_b_vld;
    logic [W_A-1:0]     r_b_a2, r_b_b2;
    t_side              r_b_side;

    assign w_pa = r_a_mp * r_a_mp;
    assign w_pb = r_a_mr * r_a_mr;

    // stage c: inner magnitude and 12*A
    logic [W_MI-1:0]  w_mi;
    logic [W_T12-1:0] w_t12;
    logic             r_c_vld;
    logic [W_MI-1:0]  r_c_mi;
    logic [W_T12-1:0] r_c_t12;
    t_side            r_c_side;

    assign w_mi  = W_MI'(r_b_a2) + THREE_W - W_MI'(r_b_b2);
    assign w_t12 = W_T12'({r_b_a2, 3'b000}) + W_T12'({r_b_a2, 2'b00});

    // stage d: square of the inner term, operand of the z-side root
    logic [W_RAD-1:0] w_sq;
    logic             r_d_vld;
    logic [W_RAD-1:0] r_d_sq;
    logic [W_T12-1:0] r_d_t12;
    logic [W_MI-1:0]  r_d_mi, r_d_pz;
    t_side            r_d_side;

    assign w_sq = r_c_mi * r_c_mi;

    // stage e: clamped radicand of the inner root
    logic [W_RAD-1:0] w_t12s, w_rad;
    logic             r_e_vld;
    logic [W_RAD-1:0] r_e_rad;
    logic [W_MI-1:0]  r_e_mi, r_e_pz;
    t_side            r_e_side;

    assign w_t12s = W_RAD'({r_d_t12, {WORK_FRAC{1'b0}}});
    assign w_rad  = (r_d_sq > w_t12s) ? (r_d_sq - w_t12s) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_mp   <= f_work(f_mag(w_p));
            r_a_mr   <= f_work(f_mag(w_r));
            r_a_side <= w_side;
            r_b_a2   <= w_pa[WORK_FRAC-1 +: W_A];
            r_b_b2   <= w_pb[WORK_FRAC-1 +: W_A];
            r_b_side <= r_a_side;
            r_c_mi   <= w_mi;
            r_c_t12  <= w_t12;
            r_c_side <= r_b_side;
            r_d_sq   <= w_sq;
            r_d_t12  <= r_c_t12;
            r_d_mi   <= r_c_mi;
            r_d_pz   <= SIX_W - r_c_mi;
            r_d_side <= r_c_side;
            r_e_rad  <= w_rad;
            r_e_mi   <= r_d_mi;
            r_e_pz   <= r_d_pz;
            r_e_side <= r_d_side;
        end
    end

    // inner root
    logic              w_s1_vld;
    logic [W_MI-1:0]   w_s1_root;
    logic [PAY1_W-1:0] w_s1_pay;
    logic [W_MI-1:0]   w_s1_mi, w_s1_pz;
    t_side             w_s1_side;

    s2c_sqrt #(.RAD_W(W_RAD), .PAY_W(PAY1_W)) u_root_inner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_e_vld),
        .i_rad   (r_e_rad),
        .i_pay   ({r_e_mi, r_e_pz, r_e_side}),
        .o_vld   (w_s1_vld),
        .o_root  (w_s1_root),
        .o_pay   (w_s1_pay)
    );

    assign {w_s1_mi, w_s1_pz, w_s1_side} = w_s1_pay;

    // stage f: clamped radicands of the two outer roots, halved in place
    logic [W_MI-1:0]   w_xt, w_zt;
    logic              r_f_vld;
    logic [W_RAD2-1:0] r_f_rx, r_f_rz;
    t_side             r_f_side;

    assign w_xt = (w_s1_mi > w_s1_root) ? (w_s1_mi - w_s1_root) : '0;
    assign w_zt = (w_s1_pz > w_s1_root) ? (w_s1_pz - w_s1_root) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= w_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_rx   <= W_RAD2'({w_xt, {(WORK_FRAC-1){1'b0}}});
            r_f_rz   <= W_RAD2'({w_zt, {(WORK_FRAC-1){1'b0}}});
            r_f_side <= w_s1_side;
        end
    end

    // outer roots, side data split between them
    logic               w_s2_vld, w_s3_vld;
    logic [W_ROOT2-1:0] w_s2_root, w_s3_root;
    logic [PAY2_W-1:0]  w_s2_pay;
    t_sgn               w_s3_sr;
    t_side              w_g_side;

    s2c_sqrt #(.RAD_W(W_RAD2), .PAY_W(PAY2_W)) u_root_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_f_vld),
        .i_rad   (r_f_rx),
        .i_pay   ({r_f_side.perm, r_f_side.sp, r_f_side.sq}),
        .o_vld   (w_s2_vld),
        .o_root  (w_s2_root),
        .o_pay   (w_s2_pay)
    );

    s2c_sqrt #(.RAD_W(W_RAD2), .PAY_W($bits(t_sgn))) u_root_third (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_f_vld),
        .i_rad   (r_f_rz),
        .i_pay   (r_f_side.sr),
        .o_vld   (w_s3_vld),
        .o_root  (w_s3_root),
        .o_pay   (w_s3_sr)
    );

    assign {w_g_side.perm, w_g_side.sp, w_g_side.sq} = w_s2_pay;
    assign w_g_side.sr = w_s3_sr;

    // output stage: round, sign, place back in axis order
    logic [FIELD_W-1:0]        w_t0, w_t1, w_t2;
    logic [FIELD_W-1:0]        w_ox, w_oy, w_oz;
    logic signed [FIELD_W-1:0] r_out_x, r_out_y, r_out_z;

    assign w_t0 = f_out(w_s2_root, w_g_side.sp);
    assign w_t1 = f_unit(w_g_side.sq);
    assign w_t2 = f_out(w_s3_root, w_g_side.sr);

    always_comb begin
        case (w_g_side.perm)
            PERM_ID: begin
                w_ox = w_t0; w_oy = w_t1; w_oz = w_t2;
            end
            PERM_SWAP_YZ: begin
                w_ox = w_t0; w_oy = w_t2; w_oz = w_t1;
            end
            PERM_X_STD: begin
                w_ox = w_t1; w_oy = w_t0; w_oz = w_t2;
            end
            PERM_X_ALT: begin
                w_ox = w_t2; w_oy = w_t0; w_oz = w_t1;
            end
            default: begin
                w_ox = w_t0; w_oy = w_t1; w_oz = w_t2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x <= w_ox;
            r_out_y <= w_oy;
            r_out_z <= w_oz;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.cube_x = r_out_x;
    assign o_out.cube_y = r_out_y;
    assign o_out.cube_z = r_out_z;

    // the two outer roots run in lockstep
    a_roots_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_vld == w_s3_vld)
        else $error("outer root pipelines out of step");

    // saturated operands never exceed one in the work format
    a_work_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> ((64'(r_a_mp) <= ONE_W) && (64'(r_a_mr) <= ONE_W)))
        else $error("work magnitude above one");

    // every result component lies within plus or minus one
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_x <= $signed(UNIT_F)) && (r_out_x >= -$signed(UNIT_F))
                    && (r_out_y <= $signed(UNIT_F)) && (r_out_y >= -$signed(UNIT_F))
                    && (r_out_z <= $signed(UNIT_F)) && (r_out_z >= -$signed(UNIT_F))))
        else $error("result component out of range");

endmodule
